// ----- rtl/c3rmp_pkg.sv -----
// Shared types and constants for the 3x3 conv / ReLU / 2x2 max-pool block.
// No dependencies; imported by the output queue and the top level.
package c3rmp_pkg;

    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;
    localparam int ROW_W      = 10;
    localparam int CFG_W      = 11;
    localparam int KSEL_W     = 3;
    localparam int TAP_W      = 4;
    localparam int KSIZE      = 3;
    localparam int NUM_TAPS   = 9;
    localparam int WEIGHT_W   = 16;
    localparam int BIAS_W     = 32;
    localparam int POS_W      = 9;
    localparam int POOLED_W   = 31;

    localparam logic [1:0] ACT_PIXEL  = 2'd0;
    localparam logic [1:0] ACT_WEIGHT = 2'd1;
    localparam logic [1:0] ACT_BIAS   = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [KSEL_W-1:0]   kernel_idx;
        logic [POS_W-1:0]    out_row;
        logic [POS_W-1:0]    out_col;
        logic [POOLED_W-1:0] pooled;
        logic                last_of_group;
        logic                last_of_frame;
    } c3rmp_result_t;

endpackage

// ----- rtl/c3rmp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module c3rmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/c3rmp_ofifo.sv -----
// Result queue between the pooling datapath and the output channel.
// Depends on c3rmp_pkg for the result beat type.
module c3rmp_ofifo
    import c3rmp_pkg::*;
#(
    parameter int DEPTH_LOG2 = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  c3rmp_result_t push_data,
    input  logic          pop,
    output logic          head_valid,
    output c3rmp_result_t head_data
);

    localparam int DEPTH = 2 ** DEPTH_LOG2;

    c3rmp_result_t             mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0]     wr_ptr_reg;
    logic [DEPTH_LOG2-1:0]     rd_ptr_reg;
    logic [DEPTH_LOG2:0]       count_reg;
    logic [DEPTH_LOG2:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/conv3x3_relu_maxpool2x2.sv -----
// Top level: streaming 3x3 convolution, bias, ReLU and 2x2 max pooling.
// Depends on c3rmp_pkg, c3rmp_ram and c3rmp_ofifo.
//
// The block takes one beat per cycle on the input channel while in_stall is
// low: a raster pixel, a weight load or a bias load. A pixel whose
// convolution window lies outside the pooled area holds up nothing; a pixel
// inside it holds the input until the sequencer has begun its last kernel,
// because a single array of nine multipliers serves the kernels one after
// another, one kernel per cycle. Every second pixel of every second
// convolution row then emits NUM_KERNELS result beats, one per kernel in
// kernel order. Weight and bias loads are taken only once the arithmetic
// pipeline has drained: a load waits until the line-load stage and stages
// s0 to s3 are all empty. Results pass through a queue of at least twice
// NUM_KERNELS beats, so the block keeps taking pixels while finished results
// wait; apart from the sequencer and load holds, input stalls only when the
// queue has no room for another full group. Two line RAMs hold the previous
// two image rows, and a partial-max RAM holds one running maximum per kernel
// and pooled column, read on every kernel step and written back on every
// step that does not emit, with the value just written forwarded to a read of
// the same entry in the next step. The user must write image width and
// height through the configuration port only while the block is idle; the
// block does not enforce this. Both are clamped to [3, MAX_WIDTH] and [3, 1024].
module conv3x3_relu_maxpool2x2
    import c3rmp_pkg::*;
#(
    parameter int NUM_KERNELS = 8,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [KSEL_W-1:0]            kernel_sel,
    input  logic [TAP_W-1:0]             tap,
    input  logic signed [PIXEL_BITS-1:0] pixel,
    input  logic signed [WEIGHT_W-1:0]   weight,
    input  logic signed [BIAS_W-1:0]     bias,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [KSEL_W-1:0]            kernel_idx,
    output logic [POS_W-1:0]             out_row,
    output logic [POS_W-1:0]             out_col,
    output logic [POOLED_W-1:0]          pooled,
    output logic                         last_of_group,
    output logic                         last_of_frame
);

    localparam int KW       = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WEW      = $clog2(MAX_WIDTH + 1);
    localparam int STRIDE   = MAX_WIDTH / 2;
    localparam int PXW      = $clog2(STRIDE);
    localparam int PDEPTH   = NUM_KERNELS * STRIDE;
    localparam int PAW      = $clog2(PDEPTH);
    localparam int PROD_W   = PIXEL_BITS + WEIGHT_W;
    localparam int SUM_BASE = (PROD_W > BIAS_W) ? PROD_W : BIAS_W;
    localparam int ACC_W    = SUM_BASE + 4;
    localparam int FLOG     = $clog2(NUM_KERNELS) + 1;
    localparam int FDEPTH   = 2 ** FLOG;
    localparam int RSV_W    = FLOG + 1;

    // per-kernel-step tag carried down the arithmetic pipeline
    typedef struct packed {
        logic [KW-1:0]    k;
        logic [PXW-1:0]   px;
        logic [POS_W-1:0] py;
        logic             first;
        logic             emit;
        logic             last_pos;
    } step_tag_t;

    function automatic logic [PAW-1:0] pool_addr(input logic [KW-1:0] k,
                                                 input logic [PXW-1:0] px);
        return PAW'(k) * PAW'(STRIDE) + PAW'(px);
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] img_w_reg;
    logic [CFG_W-1:0] img_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= CFG_W'(64);
            img_h_reg <= CFG_W'(64);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  img_w_reg <= cfg_data;
                CFG_IDX_HEIGHT: img_h_reg <= cfg_data;
                default:        img_w_reg <= img_w_reg;
            endcase
        end
    end

    logic [WEW-1:0]   w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [WEW-1:0]   x_lim;
    logic [CFG_W-1:0] y_lim;
    logic [WEW-1:0]   pool_w;
    logic [CFG_W-1:0] pool_h;

    // clamp to the legal frame size, then derive the pooled area
    always_comb
    begin
        if (img_w_reg < CFG_W'(MIN_DIM))
            w_eff = WEW'(MIN_DIM);
        else if (32'(img_w_reg) > MAX_WIDTH)
            w_eff = WEW'(MAX_WIDTH);
        else
            w_eff = WEW'(img_w_reg);

        if (img_h_reg < CFG_W'(MIN_DIM))
            h_eff = CFG_W'(MIN_DIM);
        else if (32'(img_h_reg) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = img_h_reg;

        pool_w = (w_eff - WEW'(2)) >> 1;
        pool_h = (h_eff - CFG_W'(2)) >> 1;
        x_lim  = pool_w << 1;
        y_lim  = pool_h << 1;
    end

    // ------------------------------------------------------------------
    // raster position and input acceptance
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    x_pos;
    logic [ROW_W-1:0] y_pos;
    logic [PXW-1:0]   new_px;
    logic [POS_W-1:0] new_py;
    logic             in_area;
    logic             new_first;
    logic             new_emit;
    logic             new_last;

    always_comb
    begin
        x_pos     = col_reg - CW'(2);
        y_pos     = row_reg - ROW_W'(2);
        new_px    = PXW'(x_pos >> 1);
        new_py    = POS_W'(y_pos >> 1);
        in_area   = (col_reg >= CW'(2)) && (row_reg >= ROW_W'(2))
                    && (WEW'(x_pos) < x_lim) && (CFG_W'(y_pos) < y_lim);
        new_first = !x_pos[0] && !y_pos[0];
        new_emit  = x_pos[0] && y_pos[0];
        new_last  = (WEW'(new_px) == pool_w - WEW'(1))
                    && (CFG_W'(new_py) == pool_h - CFG_W'(1));
    end

    logic             in_accept;
    logic             pix_accept;
    logic             job_go;
    logic             ksel_ok;
    logic             pipe_busy;
    logic             seq_free;
    logic             space_ok;
    logic             out_pop;
    logic [RSV_W-1:0] rsv_reg;
    logic [RSV_W-1:0] rsv_next;

    // stage registers declared ahead of the stall logic that watches them
    logic             ld_valid_reg;
    logic [CW-1:0]    ld_col_reg;
    logic signed [PIXEL_BITS-1:0] ld_pix_reg;
    logic             s0_valid_reg;
    step_tag_t        s0_tag_reg;
    logic             s1_valid_reg;
    step_tag_t        s1_tag_reg;
    logic             s2_valid_reg;
    step_tag_t        s2_tag_reg;
    logic             s3_valid_reg;
    step_tag_t        s3_tag_reg;

    assign seq_free  = !s0_valid_reg || (s0_tag_reg.k == KW'(NUM_KERNELS - 1));
    assign pipe_busy = ld_valid_reg || s0_valid_reg || s1_valid_reg
                       || s2_valid_reg || s3_valid_reg;
    assign space_ok  = (rsv_reg <= RSV_W'(FDEPTH - NUM_KERNELS));
    // hold loads until the pipeline has drained so no step sees a half-updated kernel
    assign in_stall  = !seq_free || !space_ok || ((action != ACT_PIXEL) && pipe_busy);
    assign in_accept = in_valid && !in_stall;
    assign pix_accept = in_accept && (action == ACT_PIXEL);
    assign job_go    = pix_accept && in_area;
    assign ksel_ok   = (32'(kernel_sel) < NUM_KERNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_accept)
        begin
            if (WEW'(col_reg) + WEW'(1) >= w_eff)
            begin
                col_reg <= '0;
                if (CFG_W'(row_reg) + CFG_W'(1) >= h_eff)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // reserve a full group of queue slots for every emitting pixel
    always_comb
    begin
        rsv_next = rsv_reg;
        if (job_go && new_emit)
            rsv_next = rsv_next + RSV_W'(NUM_KERNELS);
        if (out_pop)
            rsv_next = rsv_next - RSV_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsv_reg <= '0;
        else
            rsv_reg <= rsv_next;
    end

    // ------------------------------------------------------------------
    // weight and bias stores
    // ------------------------------------------------------------------
    logic [NUM_TAPS-1:0]    wvalid_reg [NUM_KERNELS];
    logic signed [BIAS_W-1:0] bias_reg [NUM_KERNELS];
    logic [WEIGHT_W-1:0]    wq [NUM_TAPS];
    logic [NUM_TAPS-1:0]    wv_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KERNELS; i++)
            begin
                wvalid_reg[i] <= '0;
                bias_reg[i]   <= '0;
            end
        end
        else if (in_accept && ksel_ok)
        begin
            if (action == ACT_WEIGHT && tap < TAP_W'(NUM_TAPS))
                wvalid_reg[KW'(kernel_sel)][tap] <= 1'b1;
            if (action == ACT_BIAS)
                bias_reg[KW'(kernel_sel)] <= bias;
        end
    end

    for (genvar t = 0; t < NUM_TAPS; t++)
    begin : g_wram
        c3rmp_ram #(
            .WIDTH(WEIGHT_W),
            .DEPTH(NUM_KERNELS)
        ) u_wram (
            .clk    (clk),
            .wr_en  (in_accept && action == ACT_WEIGHT && ksel_ok
                     && tap == TAP_W'(t)),
            .wr_addr(KW'(kernel_sel)),
            .wr_data(weight),
            .rd_addr(s0_tag_reg.k),
            .rd_data(wq[t])
        );
    end

    // ------------------------------------------------------------------
    // line stores and window
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] top_q;
    logic [PIXEL_BITS-1:0] mid_q;
    logic signed [PIXEL_BITS-1:0] win_reg [NUM_TAPS];

    c3rmp_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_top (
        .clk    (clk),
        .wr_en  (ld_valid_reg),
        .wr_addr(ld_col_reg),
        .wr_data(mid_q),
        .rd_addr(col_reg),
        .rd_data(top_q)
    );

    c3rmp_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_mid (
        .clk    (clk),
        .wr_en  (ld_valid_reg),
        .wr_addr(ld_col_reg),
        .wr_data(ld_pix_reg),
        .rd_addr(col_reg),
        .rd_data(mid_q)
    );

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            ld_col_reg <= col_reg;
            ld_pix_reg <= pixel;
        end
    end

    // shift the window left; the new column enters at the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            ld_valid_reg <= pix_accept;
            if (ld_valid_reg)
            begin
                for (int r = 0; r < KSIZE; r++)
                begin
                    win_reg[r*KSIZE]     <= win_reg[r*KSIZE + 1];
                    win_reg[r*KSIZE + 1] <= win_reg[r*KSIZE + 2];
                end
                win_reg[KSIZE - 1]     <= $signed(top_q);
                win_reg[2*KSIZE - 1]   <= $signed(mid_q);
                win_reg[NUM_TAPS - 1]  <= ld_pix_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // kernel sequencer and arithmetic pipeline
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg [NUM_TAPS];
    logic signed [BIAS_W-1:0] bias_s2_reg;
    logic signed [ACC_W-1:0]  sum_a;
    logic signed [ACC_W-1:0]  sum_b;
    logic signed [ACC_W-1:0]  sum_a_reg;
    logic signed [ACC_W-1:0]  sum_b_reg;
    logic signed [ACC_W-1:0]  acc;
    logic [POOLED_W-1:0]      conv_val;
    logic [POOLED_W-1:0]      pool_q;
    logic [POOLED_W-1:0]      pool_cur;
    logic [POOLED_W-1:0]      pool_new;
    logic                     pool_wr_en;
    logic [PAW-1:0]           pool_wr_addr;
    logic [PAW-1:0]           pool_rd_addr;
    logic                     fwd_hit_reg;
    logic [POOLED_W-1:0]      fwd_data_reg;
    step_tag_t                go_tag;

    always_comb
    begin
        go_tag.k        = '0;
        go_tag.px       = new_px;
        go_tag.py       = new_py;
        go_tag.first    = new_first;
        go_tag.emit     = new_emit;
        go_tag.last_pos = new_last;
    end

    assign pool_wr_en   = s3_valid_reg && !s3_tag_reg.emit;
    assign pool_wr_addr = pool_addr(s3_tag_reg.k, s3_tag_reg.px);
    assign pool_rd_addr = pool_addr(s2_tag_reg.k, s2_tag_reg.px);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (job_go)
                s0_valid_reg <= 1'b1;
            else if (s0_valid_reg && s0_tag_reg.k == KW'(NUM_KERNELS - 1))
                s0_valid_reg <= 1'b0;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            // the RAM returns the old entry when it is read and written at one edge
            fwd_hit_reg  <= pool_wr_en && (pool_wr_addr == pool_rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_go)
            s0_tag_reg <= go_tag;
        else if (s0_valid_reg)
            s0_tag_reg.k <= s0_tag_reg.k + KW'(1);
        s1_tag_reg <= s0_tag_reg;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        wv_s1_reg  <= wvalid_reg[s0_tag_reg.k];
        // one multiplier per tap; unwritten weights read as zero
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            prod_reg[i] <= wv_s1_reg[i]
                           ? PROD_W'(win_reg[i] * $signed(wq[i]))
                           : '0;
        end
        bias_s2_reg  <= bias_reg[s1_tag_reg.k];
        sum_a_reg    <= sum_a;
        sum_b_reg    <= sum_b;
        fwd_data_reg <= pool_new;
    end

    always_comb
    begin
        sum_a = '0;
        sum_b = ACC_W'(bias_s2_reg);
        for (int i = 0; i < 5; i++)
            sum_a = sum_a + ACC_W'(prod_reg[i]);
        for (int i = 5; i < NUM_TAPS; i++)
            sum_b = sum_b + ACC_W'(prod_reg[i]);
    end

    // ReLU and saturate, then fold into the running pool maximum
    always_comb
    begin
        acc = sum_a_reg + sum_b_reg;
        if (acc[ACC_W-1])
            conv_val = '0;
        else if (|acc[ACC_W-2:POOLED_W])
            conv_val = '1;
        else
            conv_val = acc[POOLED_W-1:0];

        pool_cur = fwd_hit_reg ? fwd_data_reg : pool_q;
        if (s3_tag_reg.first || conv_val > pool_cur)
            pool_new = conv_val;
        else
            pool_new = pool_cur;
    end

    c3rmp_ram #(
        .WIDTH(POOLED_W),
        .DEPTH(PDEPTH)
    ) u_pool (
        .clk    (clk),
        .wr_en  (pool_wr_en),
        .wr_addr(pool_wr_addr),
        .wr_data(pool_new),
        .rd_addr(pool_rd_addr),
        .rd_data(pool_q)
    );

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    c3rmp_result_t res;
    c3rmp_result_t head;
    logic          group_end;

    always_comb
    begin
        group_end         = (s3_tag_reg.k == KW'(NUM_KERNELS - 1));
        res.kernel_idx    = KSEL_W'(s3_tag_reg.k);
        res.out_row       = s3_tag_reg.py;
        res.out_col       = POS_W'(s3_tag_reg.px);
        res.pooled        = pool_new;
        res.last_of_group = group_end;
        res.last_of_frame = group_end && s3_tag_reg.last_pos;
    end

    c3rmp_ofifo #(
        .DEPTH_LOG2(FLOG)
    ) u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg && s3_tag_reg.emit),
        .push_data (res),
        .pop       (out_pop),
        .head_valid(out_valid),
        .head_data (head)
    );

    assign out_pop       = out_valid && !out_stall;
    assign kernel_idx    = head.kernel_idx;
    assign out_row       = head.out_row;
    assign out_col       = head.out_col;
    assign pooled        = head.pooled;
    assign last_of_group = head.last_of_group;
    assign last_of_frame = head.last_of_frame;

endmodule
